[design/iditok_pkg.sv]
// package for the include directive tokenizer
// holds parse modes, result kinds, error codes, byte constants and the
// item descriptor passed from the parser to the result sequencer
`timescale 1ns / 1ps
`default_nettype none

package iditok_pkg;

	// field length limit and counter width
	localparam int MAX_FIELD_LEN = 256;
	localparam int FC_W          = $clog2(MAX_FIELD_LEN) + 1;

	// configuration register indexes
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_START_PATTERN = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_START_LENGTH  = 1'd1;

	// configuration reset values: "<!--#" and five bytes
	localparam logic [63:0] START_PATTERN_RST = 64'h0000_0023_2D2D_213C;
	localparam logic [3:0]  START_LENGTH_RST  = 4'd5;

	// byte constants
	localparam logic [7:0] CH_DASH   = 8'h2D;
	localparam logic [7:0] CH_GT     = 8'h3E;
	localparam logic [7:0] CH_EQ     = 8'h3D;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_CR     = 8'h0D;

	typedef enum logic [2:0] {
		M_TEXT,
		M_DSKIP,
		M_DNAME,
		M_TSKIP,
		M_TNAME,
		M_TQUOTE,
		M_TVALUE,
		M_HALT
	} mode_t;

	typedef enum logic [3:0] {
		K_TEXT   = 4'd0,
		K_DBYTE  = 4'd1,
		K_DDONE  = 4'd2,
		K_NBYTE  = 4'd3,
		K_VBYTE  = 4'd4,
		K_TDONE  = 4'd5,
		K_CLOSED = 4'd6,
		K_ERROR  = 4'd7,
		K_END    = 4'd8
	} kind_t;

	typedef enum logic [2:0] {
		E_NONE      = 3'd0,
		E_TAG_LONG  = 3'd1,
		E_NO_QUOTE  = 3'd2,
		E_EARLY_END = 3'd3,
		E_DIR_LONG  = 3'd4
	} err_t;

	// results of one item: replayed start bytes, optional premature-end
	// error, optional final result
	typedef struct packed {
		logic [2:0] rep_n;
		logic       pre_err;
		logic       tail_vld;
		kind_t      tail_kind;
		logic [7:0] tail_byte;
		err_t       tail_err;
	} desc_t;

	function automatic logic is_ws(input logic [7:0] c);
		return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
	endfunction

	function automatic logic [7:0] pat_byte(input logic [63:0] pat, input logic [2:0] idx);
		return pat[{idx, 3'd0} +: 8];
	endfunction

endpackage

`default_nettype wire

[design/iditok_parse.sv]
// parse state machine: mode, match, field, escape and dash state
// turns one registered item into a result descriptor; uses iditok_pkg
`timescale 1ns / 1ps
`default_nettype none

module iditok_parse (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  step_en,
	input  wire [7:0]            data_byte,
	input  wire                  end_of_input,
	input  wire [63:0]           start_pattern,
	input  wire [3:0]            start_length,
	output iditok_pkg::desc_t    desc
);

	localparam logic [iditok_pkg::FC_W-1:0] FC_MAX =
		iditok_pkg::FC_W'(iditok_pkg::MAX_FIELD_LEN);
	localparam logic [iditok_pkg::FC_W-1:0] FC_ONE = iditok_pkg::FC_W'(1);

	iditok_pkg::mode_t         mode_q, mode_d;
	logic [2:0]                mc_q, mc_d;
	logic [iditok_pkg::FC_W-1:0] fc_q, fc_d;
	logic                      esc_q, esc_d;
	logic [1:0]                dc_q, dc_d;

	logic [3:0]                len_eff;
	logic [2:0]                mc_eff;
	logic [3:0]                mc_inc;
	logic [iditok_pkg::FC_W-1:0] fc_inc;
	logic                      ws;

	// tag name byte handling, shared by tag skip and tag name
	logic                      tn_esc_in;
	logic [iditok_pkg::FC_W-1:0] tn_fc_in;
	logic [iditok_pkg::FC_W-1:0] tn_fc_d;
	logic                      tn_esc_d;
	iditok_pkg::mode_t         tn_mode_d;
	logic                      tn_emit;
	logic                      tn_fail;

	// effective start length and clamped match count
	always_comb begin
		if (start_length == 4'd0) begin
			len_eff = 4'd1;
		end else if (start_length > 4'd8) begin
			len_eff = 4'd8;
		end else begin
			len_eff = start_length;
		end
		mc_eff = ({1'b0, mc_q} >= len_eff) ? 3'(len_eff - 4'd1) : mc_q;
		mc_inc = {1'b0, mc_eff} + 4'd1;
		fc_inc = fc_q + FC_ONE;
		ws     = iditok_pkg::is_ws(data_byte);
	end

	// one tag name byte
	always_comb begin
		tn_esc_in = (mode_q == iditok_pkg::M_TNAME) ? esc_q : 1'b0;
		tn_fc_in  = (mode_q == iditok_pkg::M_TNAME) ? fc_q : '0;
		tn_fc_d   = tn_fc_in;
		tn_esc_d  = 1'b0;
		tn_mode_d = iditok_pkg::M_TNAME;
		tn_emit   = 1'b0;
		tn_fail   = 1'b0;
		if (tn_esc_in) begin
			tn_emit = 1'b1;
		end else begin
			tn_fc_d = tn_fc_in + FC_ONE;
			if (tn_fc_d >= FC_MAX) begin
				tn_fail = 1'b1;
			end else if (data_byte == iditok_pkg::CH_BSLASH) begin
				tn_esc_d = 1'b1;
			end else if (data_byte == iditok_pkg::CH_EQ) begin
				tn_mode_d = iditok_pkg::M_TQUOTE;
			end else begin
				tn_emit = 1'b1;
			end
		end
	end

	// next state and result descriptor
	always_comb begin
		mode_d = mode_q;
		mc_d   = mc_eff;
		fc_d   = fc_q;
		esc_d  = esc_q;
		dc_d   = dc_q;
		desc   = '0;
		if (end_of_input) begin
			if (mode_q == iditok_pkg::M_TEXT) begin
				desc.rep_n = mc_eff;
			end else if (mode_q != iditok_pkg::M_HALT) begin
				desc.pre_err = 1'b1;
			end
			desc.tail_vld  = 1'b1;
			desc.tail_kind = iditok_pkg::K_END;
			mode_d = iditok_pkg::M_TEXT;
			mc_d   = 3'd0;
			fc_d   = '0;
			esc_d  = 1'b0;
			dc_d   = 2'd0;
		end else begin
			unique case (mode_q)
				iditok_pkg::M_TEXT: begin
					if (data_byte == iditok_pkg::pat_byte(start_pattern, mc_eff)) begin
						if (mc_inc >= len_eff) begin
							mc_d   = 3'd0;
							mode_d = iditok_pkg::M_DSKIP;
						end else begin
							mc_d = mc_inc[2:0];
						end
					end else begin
						desc.rep_n = mc_eff;
						if (data_byte == iditok_pkg::pat_byte(start_pattern, 3'd0)) begin
							mc_d = 3'd1;
						end else begin
							desc.tail_vld  = 1'b1;
							desc.tail_kind = iditok_pkg::K_TEXT;
							desc.tail_byte = data_byte;
							mc_d = 3'd0;
						end
					end
				end
				iditok_pkg::M_DSKIP: begin
					if (!ws) begin
						fc_d   = FC_ONE;
						mode_d = iditok_pkg::M_DNAME;
						desc.tail_vld  = 1'b1;
						desc.tail_kind = iditok_pkg::K_DBYTE;
						desc.tail_byte = data_byte;
					end
				end
				iditok_pkg::M_DNAME: begin
					if (ws) begin
						desc.tail_vld  = 1'b1;
						desc.tail_kind = iditok_pkg::K_DDONE;
						mode_d = iditok_pkg::M_TSKIP;
						fc_d   = '0;
						dc_d   = 2'd0;
						esc_d  = 1'b0;
					end else begin
						fc_d = fc_inc;
						desc.tail_vld = 1'b1;
						if (fc_inc >= FC_MAX) begin
							desc.tail_kind = iditok_pkg::K_ERROR;
							desc.tail_err  = iditok_pkg::E_DIR_LONG;
							mode_d = iditok_pkg::M_HALT;
							esc_d  = 1'b0;
							dc_d   = 2'd0;
						end else begin
							desc.tail_kind = iditok_pkg::K_DBYTE;
							desc.tail_byte = data_byte;
						end
					end
				end
				iditok_pkg::M_TSKIP, iditok_pkg::M_TNAME: begin
					priority if (mode_q == iditok_pkg::M_TSKIP && dc_q == 2'd0 && ws) begin
						// whitespace before a tag
					end else if (mode_q == iditok_pkg::M_TSKIP && dc_q != 2'd2
							&& data_byte == iditok_pkg::CH_DASH) begin
						dc_d = dc_q + 2'd1;
					end else if (mode_q == iditok_pkg::M_TSKIP && dc_q == 2'd2
							&& data_byte == iditok_pkg::CH_GT) begin
						desc.tail_vld  = 1'b1;
						desc.tail_kind = iditok_pkg::K_CLOSED;
						mode_d = iditok_pkg::M_TEXT;
						mc_d   = 3'd0;
						dc_d   = 2'd0;
						fc_d   = '0;
					end else begin
						dc_d = 2'd0;
						fc_d = tn_fc_d;
						if (tn_fail) begin
							desc.tail_vld  = 1'b1;
							desc.tail_kind = iditok_pkg::K_ERROR;
							desc.tail_err  = iditok_pkg::E_TAG_LONG;
							mode_d = iditok_pkg::M_HALT;
							esc_d  = 1'b0;
						end else begin
							mode_d = tn_mode_d;
							esc_d  = tn_esc_d;
							if (tn_emit) begin
								desc.tail_vld  = 1'b1;
								desc.tail_kind = iditok_pkg::K_NBYTE;
								desc.tail_byte = data_byte;
							end
						end
					end
				end
				iditok_pkg::M_TQUOTE: begin
					if (data_byte == iditok_pkg::CH_QUOTE) begin
						mode_d = iditok_pkg::M_TVALUE;
					end else begin
						desc.tail_vld  = 1'b1;
						desc.tail_kind = iditok_pkg::K_ERROR;
						desc.tail_err  = iditok_pkg::E_NO_QUOTE;
						mode_d = iditok_pkg::M_HALT;
						esc_d  = 1'b0;
						dc_d   = 2'd0;
					end
				end
				iditok_pkg::M_TVALUE: begin
					if (esc_q) begin
						esc_d = 1'b0;
						desc.tail_vld  = 1'b1;
						desc.tail_kind = iditok_pkg::K_VBYTE;
						desc.tail_byte = data_byte;
					end else begin
						fc_d = fc_inc;
						if (fc_inc >= FC_MAX) begin
							desc.tail_vld  = 1'b1;
							desc.tail_kind = iditok_pkg::K_ERROR;
							desc.tail_err  = iditok_pkg::E_TAG_LONG;
							mode_d = iditok_pkg::M_HALT;
							esc_d  = 1'b0;
							dc_d   = 2'd0;
						end else if (data_byte == iditok_pkg::CH_BSLASH) begin
							esc_d = 1'b1;
						end else if (data_byte == iditok_pkg::CH_QUOTE) begin
							desc.tail_vld  = 1'b1;
							desc.tail_kind = iditok_pkg::K_TDONE;
							mode_d = iditok_pkg::M_TSKIP;
							fc_d   = '0;
							dc_d   = 2'd0;
						end else begin
							desc.tail_vld  = 1'b1;
							desc.tail_kind = iditok_pkg::K_VBYTE;
							desc.tail_byte = data_byte;
						end
					end
				end
				iditok_pkg::M_HALT: begin
					// bytes ignored until end of input
				end
				default: begin
					mode_d = iditok_pkg::M_HALT;
				end
			endcase
		end
	end

	// parse state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= iditok_pkg::M_TEXT;
			mc_q   <= 3'd0;
			fc_q   <= '0;
			esc_q  <= 1'b0;
			dc_q   <= 2'd0;
		end else if (step_en) begin
			mode_q <= mode_d;
			mc_q   <= mc_d;
			fc_q   <= fc_d;
			esc_q  <= esc_d;
			dc_q   <= dc_d;
		end
	end

endmodule

`default_nettype wire

[design/iditok_emit.sv]
// result register and sequencer: plays out one descriptor as result items
// replayed start bytes first, then premature-end error, then the final result
`timescale 1ns / 1ps
`default_nettype none

module iditok_emit (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  load,
	input  wire iditok_pkg::desc_t desc,
	input  wire [63:0]           start_pattern,
	output logic                 can_load,
	output logic                 out_valid,
	input  wire                  out_ready,
	output logic [3:0]           kind,
	output logic [7:0]           out_byte,
	output logic [2:0]           error_code,
	output logic                 last
);

	iditok_pkg::desc_t desc_q;
	logic              vld_q;
	logic [2:0]        idx_q;
	logic              pre_q;
	logic              in_replay;
	logic              pop;

	// select the current result
	always_comb begin
		in_replay = (idx_q != desc_q.rep_n);
		if (in_replay) begin
			kind       = iditok_pkg::K_TEXT;
			out_byte   = iditok_pkg::pat_byte(start_pattern, idx_q);
			error_code = iditok_pkg::E_NONE;
			last       = (3'(idx_q + 3'd1) == desc_q.rep_n) && !pre_q && !desc_q.tail_vld;
		end else if (pre_q) begin
			kind       = iditok_pkg::K_ERROR;
			out_byte   = 8'd0;
			error_code = iditok_pkg::E_EARLY_END;
			last       = !desc_q.tail_vld;
		end else begin
			kind       = desc_q.tail_kind;
			out_byte   = desc_q.tail_byte;
			error_code = desc_q.tail_err;
			last       = 1'b1;
		end
		out_valid = vld_q;
		pop       = vld_q && out_ready;
		can_load  = !vld_q || (out_ready && last);
	end

	// sequencer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
			idx_q <= 3'd0;
			pre_q <= 1'b0;
		end else if (load) begin
			vld_q <= 1'b1;
			idx_q <= 3'd0;
			pre_q <= desc.pre_err;
		end else if (pop) begin
			if (last) begin
				vld_q <= 1'b0;
			end else if (in_replay) begin
				idx_q <= idx_q + 3'd1;
			end else begin
				pre_q <= 1'b0;
			end
		end
	end

	// descriptor payload
	always_ff @(posedge clk) begin
		if (load) begin
			desc_q <= desc;
		end
	end

endmodule

`default_nettype wire

[design/include_directive_tokenizer_top.sv]
// top level of the include directive tokenizer
// holds configuration and the input register; uses iditok_pkg, iditok_parse,
// iditok_emit
//
// usage:
//   input channel (in_valid/in_ready) carries data_byte and end_of_input,
//   one document byte per item. output channel (out_valid/out_ready)
//   carries kind, out_byte, error_code and last; last marks the final
//   result of one item. an item may give no result at all.
//   configuration: cfg_we with cfg_index 0 writes start_pattern, index 1
//   writes start_length (low four bits of cfg_data); write only when idle.
// timing:
//   an accepted item is held in the input register and is parsed in a
//   single pass into the result register, which offers its results.
//   one item per cycle is sustained while each item gives at most one
//   result and the receiver takes every result; an item with n results
//   holds the result register until all n are taken (up to eight, set by
//   the start byte replay), and items without results pass the parser
//   even while results wait.
// reset:
//   arst_n clears to text mode with no partial match and restores the start
//   sequence "<!--#" with length five. a stalled receiver holds the current
//   result; the input register fills and in_ready drops until it drains.
`timescale 1ns / 1ps
`default_nettype none

module include_directive_tokenizer_top (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              cfg_we,
	input  wire [iditok_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire [63:0]                       cfg_data,
	input  wire                              in_valid,
	output logic                             in_ready,
	input  wire [7:0]                        data_byte,
	input  wire                              end_of_input,
	output logic                             out_valid,
	input  wire                              out_ready,
	output logic [3:0]                       kind,
	output logic [7:0]                       out_byte,
	output logic [2:0]                       error_code,
	output logic                             last
);

	logic [63:0]       start_pattern_q;
	logic [3:0]        start_length_q;
	logic              item_vld_s1;
	logic [7:0]        data_s1;
	logic              eoi_s1;
	iditok_pkg::desc_t desc;
	logic              has_res;
	logic              can_load;
	logic              adv;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_pattern_q <= iditok_pkg::START_PATTERN_RST;
			start_length_q  <= iditok_pkg::START_LENGTH_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				iditok_pkg::REG_START_PATTERN: start_pattern_q <= cfg_data;
				iditok_pkg::REG_START_LENGTH:  start_length_q  <= cfg_data[3:0];
				default: begin
				end
			endcase
		end
	end

	// handshake between input register and result register
	always_comb begin
		has_res  = (desc.rep_n != 3'd0) || desc.pre_err || desc.tail_vld;
		adv      = item_vld_s1 && (!has_res || can_load);
		in_ready = !item_vld_s1 || adv;
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_vld_s1 <= 1'b0;
		end else if (in_ready) begin
			item_vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s1 <= data_byte;
			eoi_s1  <= end_of_input;
		end
	end

	iditok_parse u_parse (
		.clk           (clk),
		.arst_n        (arst_n),
		.step_en       (adv),
		.data_byte     (data_s1),
		.end_of_input  (eoi_s1),
		.start_pattern (start_pattern_q),
		.start_length  (start_length_q),
		.desc          (desc)
	);

	iditok_emit u_emit (
		.clk           (clk),
		.arst_n        (arst_n),
		.load          (adv && has_res),
		.desc          (desc),
		.start_pattern (start_pattern_q),
		.can_load      (can_load),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.kind          (kind),
		.out_byte      (out_byte),
		.error_code    (error_code),
		.last          (last)
	);

endmodule

`default_nettype wire

[sim/testbench.sv]
// self-checking testbench for include_directive_tokenizer_top
// predicts every result item from a model of the tokenizer in this file;
// depends on iditok_pkg and the design sources only
`timescale 1ns / 1ps

module testbench;
	import iditok_pkg::*;

	// one document byte offered to the block
	typedef struct packed {
		logic [7:0] data;
		logic       eoi;
	} doc_item_t;

	// one result item as the block should give it
	typedef struct packed {
		kind_t      kind;
		logic [7:0] data;
		err_t       err;
		logic       last;
	} token_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = REG_START_PATTERN;
	logic [63:0] cfg_data = 64'd0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [7:0] data_byte = 8'd0;
	logic end_of_input = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [3:0] kind;
	logic [7:0] out_byte;
	logic [2:0] error_code;
	logic last;

	doc_item_t doc_bytes[$];
	token_t expected_tokens[$];
	token_t step_tokens[$];
	int items_queued = 0;
	int mismatches = 0;
	int send_idle_pct = 33;
	int recv_idle_pct = 81;
	int stall_requests = 0;

	// tokenizer model: configuration and parse state
	logic [63:0] cfg_pattern = START_PATTERN_RST;
	logic [3:0] cfg_length = START_LENGTH_RST;
	mode_t pmode = M_TEXT;
	int matched = 0;
	int fcount = 0;
	int dashes = 0;
	bit esc = 1'b0;

	include_directive_tokenizer_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.data_byte(data_byte),
		.end_of_input(end_of_input),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.kind(kind),
		.out_byte(out_byte),
		.error_code(error_code),
		.last(last)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic blank_char(input logic [7:0] c);
		return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
	endfunction

	function automatic logic [7:0] opener_byte(input int i);
		return cfg_pattern[(i % 8) * 8 +: 8];
	endfunction

	// length register is clamped to 1..8
	function automatic int opener_length();
		if (cfg_length == 4'd0)
			return 1;
		if (cfg_length > 4'd8)
			return 8;
		return int'(cfg_length);
	endfunction

	task automatic emit(input kind_t k, input logic [7:0] d, input err_t e);
		step_tokens.push_back('{k, d, e, 1'b0});
	endtask

	task automatic halt(input err_t e);
		emit(K_ERROR, 8'd0, e);
		pmode = M_HALT;
		esc = 1'b0;
		dashes = 0;
	endtask

	task automatic name_byte(input logic [7:0] c);
		if (esc) begin
			esc = 1'b0;
			emit(K_NBYTE, c, E_NONE);
		end else begin
			fcount++;
			if (fcount >= MAX_FIELD_LEN)
				halt(E_TAG_LONG);
			else if (c == CH_BSLASH)
				esc = 1'b1;
			else if (c == CH_EQ)
				pmode = M_TQUOTE;
			else
				emit(K_NBYTE, c, E_NONE);
		end
	endtask

	// advance the model by one item and queue the results it causes
	task automatic tokenize(input logic [7:0] c, input logic eoi);
		int len;
		int i;
		step_tokens.delete();
		len = opener_length();
		if (matched >= len)
			matched = len - 1;
		if (eoi) begin
			if (pmode == M_TEXT) begin
				for (i = 0; i < matched; i++)
					emit(K_TEXT, opener_byte(i), E_NONE);
			end else if (pmode != M_HALT) begin
				emit(K_ERROR, 8'd0, E_EARLY_END);
			end
			emit(K_END, 8'd0, E_NONE);
			pmode = M_TEXT;
			matched = 0;
			fcount = 0;
			esc = 1'b0;
			dashes = 0;
		end else begin
			case (pmode)
				M_TEXT: begin
					if (c == opener_byte(matched)) begin
						matched++;
						if (matched >= len) begin
							matched = 0;
							pmode = M_DSKIP;
						end
					end else begin
						// failed partial match: replay, maybe restart on this byte
						for (i = 0; i < matched; i++)
							emit(K_TEXT, opener_byte(i), E_NONE);
						if (c == opener_byte(0)) begin
							matched = 1;
						end else begin
							emit(K_TEXT, c, E_NONE);
							matched = 0;
						end
					end
				end
				M_DSKIP: begin
					if (!blank_char(c)) begin
						fcount = 1;
						emit(K_DBYTE, c, E_NONE);
						pmode = M_DNAME;
					end
				end
				M_DNAME: begin
					if (blank_char(c)) begin
						emit(K_DDONE, 8'd0, E_NONE);
						pmode = M_TSKIP;
						fcount = 0;
						dashes = 0;
						esc = 1'b0;
					end else begin
						fcount++;
						if (fcount >= MAX_FIELD_LEN)
							halt(E_DIR_LONG);
						else
							emit(K_DBYTE, c, E_NONE);
					end
				end
				M_TSKIP: begin
					// blanks, then up to two dashes that either close or get dropped
					if (dashes == 0 && blank_char(c)) begin
					end else if (dashes < 2 && c == CH_DASH) begin
						dashes++;
					end else if (dashes == 2 && c == CH_GT) begin
						emit(K_CLOSED, 8'd0, E_NONE);
						pmode = M_TEXT;
						matched = 0;
						dashes = 0;
						fcount = 0;
					end else begin
						dashes = 0;
						fcount = 0;
						esc = 1'b0;
						pmode = M_TNAME;
						name_byte(c);
					end
				end
				M_TNAME: name_byte(c);
				M_TQUOTE: begin
					if (c == CH_QUOTE)
						pmode = M_TVALUE;
					else
						halt(E_NO_QUOTE);
				end
				M_TVALUE: begin
					if (esc) begin
						esc = 1'b0;
						emit(K_VBYTE, c, E_NONE);
					end else begin
						fcount++;
						if (fcount >= MAX_FIELD_LEN) begin
							halt(E_TAG_LONG);
						end else if (c == CH_BSLASH) begin
							esc = 1'b1;
						end else if (c == CH_QUOTE) begin
							emit(K_TDONE, 8'd0, E_NONE);
							pmode = M_TSKIP;
							fcount = 0;
							dashes = 0;
						end else begin
							emit(K_VBYTE, c, E_NONE);
						end
					end
				end
				default: pmode = M_HALT;
			endcase
		end
		if (step_tokens.size() > 0)
			step_tokens[$].last = 1'b1;
		foreach (step_tokens[j])
			expected_tokens.push_back(step_tokens[j]);
	endtask

	// sender: predict on accept, then offer the next pending item or idle
	always @(posedge clk) begin : driver
		doc_item_t nxt;
		if (in_valid && in_ready)
			tokenize(data_byte, end_of_input);
		if (!in_valid || in_ready) begin
			if (doc_bytes.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
				nxt = doc_bytes.pop_front();
				in_valid <= 1'b1;
				data_byte <= nxt.data;
				end_of_input <= nxt.eoi;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver: check each accepted result, stall at random or for a long stretch
	always @(posedge clk) begin : monitor
		token_t exp;
		int stall_left;
		int stall_served;
		if (out_valid && out_ready) begin
			if (expected_tokens.size() == 0) begin
				mismatches++;
				if (mismatches <= 50)
					$display("%0t: unexpected result kind %0d byte %02h code %0d last %0b",
						$time, kind, out_byte, error_code, last);
			end else begin
				exp = expected_tokens.pop_front();
				if (kind !== exp.kind || out_byte !== exp.data || error_code !== exp.err
						|| last !== exp.last) begin
					mismatches++;
					if (mismatches <= 50)
						$display({"%0t: result mismatch: expected kind %0d byte %02h code %0d",
							" last %0b, got kind %0d byte %02h code %0d last %0b"},
							$time, exp.kind, exp.data, exp.err, exp.last,
							kind, out_byte, error_code, last);
				end
			end
		end
		if (stall_left > 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else if (stall_requests != stall_served) begin
			stall_served++;
			stall_left = 300;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	task automatic push_item(input logic [7:0] d, input logic e);
		doc_bytes.push_back('{d, e});
		items_queued++;
	endtask

	task automatic push_text(input string s);
		foreach (s[i])
			push_item(s[i], 1'b0);
	endtask

	function automatic logic [7:0] random_blank();
		int k;
		k = $urandom_range(0, 5);
		return (k == 5) ? CH_SPACE : 8'(CH_TAB + k);
	endfunction

	function automatic logic [7:0] random_letter();
		return 8'(8'h61 + $urandom_range(0, 25));
	endfunction

	// one document; long_sel 1..3 stretches the directive name, tag name or value
	task automatic gen_document(input int long_sel);
		int len;
		int ntags;
		int n;
		int t;
		int i;
		int broken;
		logic [7:0] b;
		len = opener_length();
		repeat ($urandom_range(0, 3))
			push_item(8'($urandom_range(0, 255)), 1'b0);
		// opener that breaks off early
		if (len > 1 && $urandom_range(0, 3) == 0) begin
			n = $urandom_range(1, len - 1);
			for (i = 0; i < n; i++)
				push_item(opener_byte(i), 1'b0);
			push_item(8'($urandom_range(0, 255)), 1'b0);
		end
		for (i = 0; i < len; i++)
			push_item(opener_byte(i), 1'b0);
		// broken: 1 missing quote, 2 end inside directive, 3 stray byte after tags
		broken = (long_sel == 0 && $urandom_range(0, 9) < 3) ? $urandom_range(1, 3) : 0;
		repeat ($urandom_range(0, 2))
			push_item(random_blank(), 1'b0);
		n = (long_sel == 1) ? $urandom_range(253, 257) : $urandom_range(1, 6);
		repeat (n) begin
			b = 8'($urandom_range(0, 255));
			if (blank_char(b) || $urandom_range(0, 3) != 0)
				b = random_letter();
			push_item(b, 1'b0);
		end
		if (broken == 2) begin
			push_item(8'($urandom_range(0, 255)), 1'b1);
			return;
		end
		push_item(random_blank(), 1'b0);
		ntags = (long_sel > 1) ? 1 : $urandom_range((broken == 1) ? 1 : 0, 3);
		for (t = 0; t < ntags; t++) begin
			repeat ($urandom_range(0, 1))
				push_item(random_blank(), 1'b0);
			case ($urandom_range(0, 5))
				0: push_item(CH_DASH, 1'b0);
				1: begin
					push_item(CH_DASH, 1'b0);
					push_item(CH_DASH, 1'b0);
				end
				default: ;
			endcase
			n = (long_sel == 2) ? $urandom_range(252, 256) : $urandom_range(1, 4);
			repeat (n) begin
				if ($urandom_range(0, 7) == 0) begin
					push_item(CH_BSLASH, 1'b0);
					push_item(8'($urandom_range(0, 255)), 1'b0);
				end else begin
					push_item(random_letter(), 1'b0);
				end
			end
			push_item(CH_EQ, 1'b0);
			if (broken == 1) begin
				push_item(random_letter(), 1'b0);
				repeat ($urandom_range(0, 3))
					push_item(8'($urandom_range(0, 255)), 1'b0);
				push_item(8'($urandom_range(0, 255)), 1'b1);
				return;
			end
			push_item(CH_QUOTE, 1'b0);
			n = (long_sel == 3) ? $urandom_range(250, 256) : $urandom_range(0, 5);
			repeat (n) begin
				b = 8'($urandom_range(0, 255));
				if (b == CH_QUOTE || b == CH_BSLASH || $urandom_range(0, 9) == 0)
					push_item(CH_BSLASH, 1'b0);
				push_item(b, 1'b0);
			end
			push_item(CH_QUOTE, 1'b0);
		end
		if (broken == 3)
			push_item(8'($urandom_range(0, 255)), 1'b0);
		repeat ($urandom_range(0, 1))
			push_item(random_blank(), 1'b0);
		push_item(CH_DASH, 1'b0);
		push_item(CH_DASH, 1'b0);
		push_item(CH_GT, 1'b0);
		if (broken != 0 || long_sel != 0 || $urandom_range(0, 2) == 0)
			push_item(8'($urandom_range(0, 255)), 1'b1);
	endtask

	task automatic gen_batch(input int count);
		int start;
		start = items_queued;
		while (items_queued - start < count)
			gen_document(0);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_START_PATTERN)
			cfg_pattern = value;
		else
			cfg_length = value[3:0];
		@(negedge clk);
	endtask

	// wait until every item is taken and every result is in, then let the block drain
	task automatic settle();
		int guard;
		guard = 0;
		while ((doc_bytes.size() != 0 || in_valid || expected_tokens.size() != 0)
				&& guard < 200000) begin
			@(negedge clk);
			guard++;
		end
		repeat (8) @(negedge clk);
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: byte extremes, replay and restart, escapes, dropped dash,
		// end with a partial match, missing quote with ignored bytes while halted
		push_item(8'h00, 1'b0);
		push_item(8'hFF, 1'b0);
		push_text("<!x");
		push_text("<<!--# i -\\==\"\\\"\" -->");
		push_text("<!-");
		push_item(8'h00, 1'b1);
		push_text("<!--#x =qz");
		push_item(8'hFF, 1'b1);
		// leave four opener bytes matched across the next register change
		push_text("<!--");
		settle();

		// shorter opener while a match is pending, long receiver hold-off
		write_reg(REG_START_PATTERN, {$urandom, $urandom});
		write_reg(REG_START_LENGTH, 64'd2);
		gen_batch(15);
		stall_requests++;
		gen_batch(15);
		settle();

		// all-ones opener, length above range; sender pauses mid-phase
		send_idle_pct = 81;
		recv_idle_pct = 33;
		write_reg(REG_START_PATTERN, {64{1'b1}});
		write_reg(REG_START_LENGTH, 64'd15);
		gen_batch(15);
		settle();
		gen_batch(15);
		settle();

		// zero opener, length zero
		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_reg(REG_START_PATTERN, 64'd0);
		write_reg(REG_START_LENGTH, 64'd0);
		gen_batch(15);
		settle();

		// random eight-byte opener
		write_reg(REG_START_PATTERN, {$urandom, $urandom});
		write_reg(REG_START_LENGTH, 64'd8);
		gen_batch(15);
		settle();

		if (expected_tokens.size() != 0) begin
			mismatches++;
			$display("%0t: %0d expected results never arrived", $time, expected_tokens.size());
		end
		if (mismatches == 0)
			$display("** include_directive_tokenizer_top: PASSED **");
		else
			$display("** include_directive_tokenizer_top: FAILED **");
		$finish;
	end

	initial begin
		#10_000_000;
		$display("** include_directive_tokenizer_top: FAILED **");
		$finish;
	end

endmodule
